FILE: hw/rtl/psm_pkg.sv
// Shared constants, codes and types of the polyphonic sample mixer.
package psm_pkg;

  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned FRAME_BITS   = 2 * SAMPLE_BITS;
  localparam int unsigned STORE_FRAMES = 65536;
  localparam int unsigned STORE_AW     = $clog2(STORE_FRAMES);
  localparam int unsigned VOICES_DEF   = 16;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned START_W      = 16;
  localparam int unsigned COUNT_W      = 17;
  localparam int unsigned SLOT_W       = 4;

  localparam int SAMPLE_MAX = 8388607;
  localparam int SAMPLE_MIN = -8388608;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic KIND_MIX   = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] frames;
    logic [COUNT_W-1:0] pos;
  } voice_t;

  typedef struct packed {
    logic                clear;
    logic                rd_valid;
    logic [STORE_AW-1:0] rd_addr;
  } mix_ctrl_t;

  typedef struct packed {
    logic              done;
    logic              kind;
    logic              accepted;
    logic [SLOT_W-1:0] slot;
  } seq_status_t;

endpackage

FILE: hw/rtl/psm_mix.sv
// Sample store memory, per-tick accumulators and output folding.
module psm_mix #(
  parameter int unsigned VOICES = psm_pkg::VOICES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [psm_pkg::STORE_AW-1:0]        wr_addr_i,
  input  logic [psm_pkg::FRAME_BITS-1:0]      wr_data_i,
  input  psm_pkg::mix_ctrl_t                  ctrl_i,
  output logic [psm_pkg::SAMPLE_BITS-1:0]     left_o,
  output logic [psm_pkg::SAMPLE_BITS-1:0]     right_o
);
  import psm_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(VOICES) + 1;
  localparam int unsigned FW    = SUM_W + 2;

  logic [FRAME_BITS-1:0]   store [STORE_FRAMES];
  logic [FRAME_BITS-1:0]   rd_data_q;
  logic                    s2_valid_q;
  logic signed [SUM_W-1:0] acc_l_q, acc_l_d;
  logic signed [SUM_W-1:0] acc_r_q, acc_r_d;
  logic signed [SUM_W-1:0] samp_l, samp_r;

  function automatic logic [SAMPLE_BITS-1:0] fold(input logic signed [SUM_W-1:0] s);
    logic signed [FW-1:0] r;
    logic signed [FW-1:0] mx;
    logic signed [FW-1:0] mn;
    logic signed [FW-1:0] e;
    r  = FW'(s);
    mx = FW'(SAMPLE_MAX);
    mn = FW'(SAMPLE_MIN);
    if (r > mx) begin
      e = r - mx;
      r = mx - (e >>> 1);
    end
    if (r < mn) begin
      e = mn - r;
      r = mn + (e >>> 1);
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_valid) begin
      rd_data_q <= store[ctrl_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= ctrl_i.rd_valid;
    end
  end

  assign samp_l = {{(SUM_W-SAMPLE_BITS){rd_data_q[SAMPLE_BITS-1]}},
                   rd_data_q[SAMPLE_BITS-1:0]};
  assign samp_r = {{(SUM_W-SAMPLE_BITS){rd_data_q[FRAME_BITS-1]}},
                   rd_data_q[FRAME_BITS-1:SAMPLE_BITS]};

  always_comb begin
    acc_l_d = acc_l_q;
    acc_r_d = acc_r_q;
    if (ctrl_i.clear) begin
      acc_l_d = '0;
      acc_r_d = '0;
    end else if (s2_valid_q) begin
      acc_l_d = acc_l_q + samp_l;
      acc_r_d = acc_r_q + samp_r;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_l_q <= acc_l_d;
    acc_r_q <= acc_r_d;
  end

  assign left_o  = fold(acc_l_q);
  assign right_o = fold(acc_r_q);

endmodule

FILE: hw/rtl/psm_voice_seq.sv
// Voice table memory, voice allocation scan and tick sequencer.
module psm_voice_seq #(
  parameter int unsigned VOICES = psm_pkg::VOICES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_i,
  input  logic [psm_pkg::OP_W-1:0]        op_i,
  input  logic [psm_pkg::START_W-1:0]     start_address_i,
  input  logic [psm_pkg::COUNT_W-1:0]     frame_count_i,
  input  logic                            out_free_i,
  output logic                            ready_o,
  output psm_pkg::mix_ctrl_t              mix_ctrl_o,
  output psm_pkg::seq_status_t            status_o
);
  import psm_pkg::*;

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [VW-1:0]      idx_q, idx_d;
  logic               drain_q, drain_d;
  logic [START_W-1:0] start_q;
  logic [COUNT_W-1:0] frames_q;
  logic               kind_q, kind_d;
  logic               acc_q, acc_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [VOICES-1:0]  active_q;
  logic               s1_valid_q;
  logic [VW-1:0]      s1_idx_q;

  voice_t             vmem [VOICES];
  voice_t             vrd_q;
  voice_t             vwdata;
  logic               vwe;
  logic [VW-1:0]      vwaddr;
  logic [COUNT_W-1:0] new_pos;
  logic               claim;
  logic               release_voice;

  assign claim         = (state_q == S_SCAN) && !active_q[idx_q];
  assign new_pos       = vrd_q.pos + COUNT_W'(1);
  assign release_voice = s1_valid_q && (new_pos >= vrd_q.frames);

  always_comb begin
    vwe    = 1'b0;
    vwaddr = idx_q;
    vwdata = '0;
    if (claim) begin
      vwe           = 1'b1;
      vwdata.start  = start_q;
      vwdata.frames = frames_q;
    end else if (s1_valid_q) begin
      vwe           = 1'b1;
      vwaddr        = s1_idx_q;
      vwdata.start  = vrd_q.start;
      vwdata.frames = vrd_q.frames;
      vwdata.pos    = new_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vmem[vwaddr] <= vwdata;
    end
    if (state_q == S_TICK) begin
      vrd_q <= vmem[idx_q];
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    drain_d = drain_q;
    kind_d  = kind_q;
    acc_d   = acc_q;
    slot_d  = slot_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i) begin
          idx_d   = '0;
          drain_d = 1'b0;
          acc_d   = 1'b0;
          slot_d  = '0;
          unique case (op_i)
            OP_START: begin
              kind_d  = KIND_START;
              state_d = S_SCAN;
            end
            OP_TICK: begin
              kind_d  = KIND_MIX;
              state_d = S_TICK;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (claim) begin
          acc_d   = 1'b1;
          slot_d  = SLOT_W'(idx_q);
          state_d = S_DONE;
        end else if (idx_q == LAST_VOICE) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + VW'(1);
        end
      end
      S_TICK: begin
        if (idx_q == LAST_VOICE) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + VW'(1);
        end
      end
      S_DRAIN: begin
        if (drain_q) begin
          state_d = S_DONE;
        end else begin
          drain_d = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      drain_q    <= 1'b0;
      kind_q     <= KIND_MIX;
      acc_q      <= 1'b0;
      slot_q     <= '0;
      active_q   <= '0;
      s1_valid_q <= 1'b0;
      s1_idx_q   <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      drain_q    <= drain_d;
      kind_q     <= kind_d;
      acc_q      <= acc_d;
      slot_q     <= slot_d;
      s1_valid_q <= (state_q == S_TICK) && active_q[idx_q];
      s1_idx_q   <= idx_q;
      if (claim) begin
        active_q[idx_q] <= 1'b1;
      end
      if (release_voice) begin
        active_q[s1_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i && (state_q == S_IDLE) && (op_i == OP_START)) begin
      start_q  <= start_address_i;
      frames_q <= frame_count_i;
    end
  end

  assign ready_o             = (state_q == S_IDLE);
  assign mix_ctrl_o.clear    = req_i && (op_i == OP_TICK);
  assign mix_ctrl_o.rd_valid = s1_valid_q;
  assign mix_ctrl_o.rd_addr  = STORE_AW'(vrd_q.start + vrd_q.pos[START_W-1:0]);
  assign status_o.done       = (state_q == S_DONE);
  assign status_o.kind       = kind_q;
  assign status_o.accepted   = acc_q;
  assign status_o.slot       = slot_q;

endmodule

FILE: hw/rtl/polyphonic_sample_mixer.sv
// Top level of the polyphonic sample mixer: request handshake and result register.
// A write request gives no result; the next request is taken at once.
// A start request scans one voice slot per cycle.
// A tick request visits one voice per cycle through the voice and sample memories,
// and no new request is taken until its result is loaded into the result register.
// Reset clears all voices to idle; the sample store holds no defined data until written.
module polyphonic_sample_mixer #(
  parameter int unsigned VOICES = psm_pkg::VOICES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [psm_pkg::OP_W-1:0]            operation_i,
  input  logic [psm_pkg::STORE_AW-1:0]        sample_address_i,
  input  logic signed [psm_pkg::SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [psm_pkg::SAMPLE_BITS-1:0] right_in_i,
  input  logic [psm_pkg::START_W-1:0]         start_address_i,
  input  logic [psm_pkg::COUNT_W-1:0]         frame_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                result_kind_o,
  output logic signed [psm_pkg::SAMPLE_BITS-1:0] left_out_o,
  output logic signed [psm_pkg::SAMPLE_BITS-1:0] right_out_o,
  output logic                                accepted_o,
  output logic [psm_pkg::SLOT_W-1:0]          slot_o
);
  import psm_pkg::*;

  logic                   accept;
  logic                   out_free;
  logic                   load;
  mix_ctrl_t              mix_ctrl;
  seq_status_t            status;
  logic [SAMPLE_BITS-1:0] mix_left;
  logic [SAMPLE_BITS-1:0] mix_right;

  logic                   out_valid_q;
  logic                   kind_q;
  logic [SAMPLE_BITS-1:0] left_q;
  logic [SAMPLE_BITS-1:0] right_q;
  logic                   acc_q;
  logic [SLOT_W-1:0]      slot_q;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign load     = status.done && out_free;

  psm_voice_seq #(
    .VOICES(VOICES)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (accept),
    .op_i           (operation_i),
    .start_address_i(start_address_i),
    .frame_count_i  (frame_count_i),
    .out_free_i     (out_free),
    .ready_o        (in_ready_o),
    .mix_ctrl_o     (mix_ctrl),
    .status_o       (status)
  );

  psm_mix #(
    .VOICES(VOICES)
  ) u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (accept && (operation_i == OP_WRITE)),
    .wr_addr_i(sample_address_i),
    .wr_data_i({right_in_i, left_in_i}),
    .ctrl_i   (mix_ctrl),
    .left_o   (mix_left),
    .right_o  (mix_right)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= status.kind;
      acc_q   <= status.accepted;
      slot_q  <= status.slot;
      left_q  <= (status.kind == KIND_START) ? '0 : mix_left;
      right_q <= (status.kind == KIND_START) ? '0 : mix_right;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign left_out_o    = left_q;
  assign right_out_o   = right_q;
  assign accepted_o    = acc_q;
  assign slot_o        = slot_q;

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (operation_i == OP_TICK)) |=> !in_ready_o)
    else $error("Tick request did not occupy the sequencer.");

  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (operation_i == OP_WRITE)) |=> in_ready_o)
    else $error("Write request stalled the request channel.");

  a_mix_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o == KIND_MIX)) |-> (!accepted_o && (slot_o == '0)))
    else $error("Mixed frame carries allocation fields.");

  a_reject_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o == KIND_START) && !accepted_o) |->
      ((slot_o == '0) && (left_out_o == '0) && (right_out_o == '0)))
    else $error("Rejected start carries a slot or sample data.");

endmodule
